[rtl/pfmd_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pfmd_pkg
// Shared widths, register indexes, reset values and bundles for the PIR frame
// motion detector.
// ----------------------------------------------------------------------------
package pfmd_pkg;

  localparam int FRAME_W   = 19;
  localparam int SAMPLE_W  = 16;
  localparam int THRESH_W  = 13;
  localparam int STABLE_W  = 8;
  localparam int HITS_W    = 2;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DAT_W = 16;

  localparam logic [2:0] CHECK_OK = 3'b100;
  localparam logic [STABLE_W-1:0] STABLE_MAX = '1;

  localparam logic [CFG_IDX_W-1:0] REG_MOTION_THRESHOLD = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MAGNITUDE_LIMIT  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_STEP_LIMIT       = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_STABLE_NEEDED    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_HITS_NEEDED      = 3'd4;

  localparam logic [THRESH_W-1:0] RST_MOTION_THRESHOLD = 13'd40;
  localparam logic [SAMPLE_W-1:0] RST_MAGNITUDE_LIMIT  = 16'd5000;
  localparam logic [SAMPLE_W-1:0] RST_STEP_LIMIT       = 16'd200;
  localparam logic [STABLE_W-1:0] RST_STABLE_NEEDED    = 8'd20;
  localparam logic [HITS_W-1:0]   RST_HITS_NEEDED      = 2'd3;

  typedef struct packed {
    logic [THRESH_W-1:0] motion_threshold;
    logic [SAMPLE_W-1:0] magnitude_limit;
    logic [SAMPLE_W-1:0] step_limit;
    logic [STABLE_W-1:0] stable_needed;
    logic [HITS_W-1:0]   hits_needed;
  } cfg_t;

  typedef struct packed {
    logic [SAMPLE_W-1:0] sample_value;
    logic                frame_valid;
    logic                motion;
  } result_t;

endpackage

[rtl/pfmd_cfg_regs.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pfmd_cfg_regs
// Configuration register bank. Writes are masked to each register's width;
// indexes past the last register are dropped.
// ----------------------------------------------------------------------------
module pfmd_cfg_regs (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_we,
  input  logic [pfmd_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [pfmd_pkg::CFG_DAT_W-1:0]    cfg_wdata,
  output pfmd_pkg::cfg_t                    cfg
);
  import pfmd_pkg::*;

  cfg_t cfg_r, cfg_nxt;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      case (cfg_index)
        REG_MOTION_THRESHOLD: cfg_nxt.motion_threshold = cfg_wdata[THRESH_W-1:0];
        REG_MAGNITUDE_LIMIT:  cfg_nxt.magnitude_limit  = cfg_wdata[SAMPLE_W-1:0];
        REG_STEP_LIMIT:       cfg_nxt.step_limit       = cfg_wdata[SAMPLE_W-1:0];
        REG_STABLE_NEEDED:    cfg_nxt.stable_needed    = cfg_wdata[STABLE_W-1:0];
        REG_HITS_NEEDED:      cfg_nxt.hits_needed      = cfg_wdata[HITS_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.motion_threshold <= RST_MOTION_THRESHOLD;
      cfg_r.magnitude_limit  <= RST_MAGNITUDE_LIMIT;
      cfg_r.step_limit       <= RST_STEP_LIMIT;
      cfg_r.stable_needed    <= RST_STABLE_NEEDED;
      cfg_r.hits_needed      <= RST_HITS_NEEDED;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

[rtl/pfmd_core.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pfmd_core
// Frame decode and motion evaluation. Holds the tracking state, which is
// updated on the cycle a frame moves into the result register.
// ----------------------------------------------------------------------------
module pfmd_core (
  input  logic                            clk,
  input  logic                            rst_n,
  input  pfmd_pkg::cfg_t                  cfg,
  input  logic                            upd,
  input  logic [pfmd_pkg::FRAME_W-1:0]    frame,
  output pfmd_pkg::result_t               result
);
  import pfmd_pkg::*;

  logic [SAMPLE_W-1:0] prev_sample_r, prev_sample_nxt;
  logic [SAMPLE_W-1:0] prev_step_r, prev_step_nxt;
  logic [STABLE_W-1:0] stable_cnt_r, stable_cnt_nxt;
  logic [HITS_W-1:0]   hit_cnt_r, hit_cnt_nxt;

  logic [2:0]          check;
  logic                valid;
  logic [SAMPLE_W-1:0] raw_sample;
  logic [SAMPLE_W-1:0] sample;
  logic [SAMPLE_W-1:0] step;
  logic [STABLE_W-1:0] stable_inc;
  logic                hit;
  logic                motion;

  assign check      = {frame[FRAME_W-1], frame[FRAME_W-2], frame[0]};
  assign valid      = (check == CHECK_OK);
  assign raw_sample = frame[SAMPLE_W:1];

  always_comb begin
    // The most negative code negates to itself and is kept as is.
    sample = raw_sample;
    if (valid && raw_sample[SAMPLE_W-1]) begin
      sample = ~raw_sample + SAMPLE_W'(1);
    end

    if (sample > prev_sample_r) begin
      step = sample - prev_sample_r;
    end else if (sample < prev_sample_r) begin
      step = prev_sample_r - sample;
    end else begin
      step = prev_step_r;
    end

    stable_inc = (stable_cnt_r == STABLE_MAX) ? stable_cnt_r
                                              : stable_cnt_r + STABLE_W'(1);
    hit = ({3'd0, cfg.motion_threshold} < sample) && (stable_inc > cfg.stable_needed);

    prev_sample_nxt = prev_sample_r;
    prev_step_nxt   = prev_step_r;
    stable_cnt_nxt  = stable_cnt_r;
    hit_cnt_nxt     = hit_cnt_r;
    motion          = 1'b0;

    if (valid) begin
      prev_sample_nxt = sample;
      if (sample < cfg.magnitude_limit) begin
        prev_step_nxt = step;
        if (step < cfg.step_limit) begin
          stable_cnt_nxt = stable_inc;
          if (!hit) begin
            hit_cnt_nxt = '0;
          end else if (hit_cnt_r < cfg.hits_needed) begin
            hit_cnt_nxt = hit_cnt_r + HITS_W'(1);
          end else begin
            hit_cnt_nxt = '0;
            motion      = 1'b1;
          end
        end else begin
          stable_cnt_nxt = '0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_sample_r <= '0;
      prev_step_r   <= '0;
      stable_cnt_r  <= '0;
      hit_cnt_r     <= '0;
    end else if (upd) begin
      prev_sample_r <= prev_sample_nxt;
      prev_step_r   <= prev_step_nxt;
      stable_cnt_r  <= stable_cnt_nxt;
      hit_cnt_r     <= hit_cnt_nxt;
    end
  end

  assign result.sample_value = sample;
  assign result.frame_valid  = valid;
  assign result.motion       = motion;

  // Motion is only ever raised by a valid frame.
  a_motion_needs_valid: assert property (@(posedge clk) disable iff (!rst_n)
    result.motion |-> result.frame_valid)
    else $error("motion raised on a frame with a bad check code");

  // A rejected frame leaves all tracking state alone.
  a_invalid_keeps_state: assert property (@(posedge clk) disable iff (!rst_n)
    (upd && !valid) |=> ($stable(prev_sample_r) && $stable(prev_step_r) &&
                         $stable(stable_cnt_r) && $stable(hit_cnt_r)))
    else $error("tracking state changed on an invalid frame");

  // State only moves when a frame is consumed.
  a_idle_keeps_state: assert property (@(posedge clk) disable iff (!rst_n)
    !upd |=> ($stable(prev_sample_r) && $stable(stable_cnt_r) && $stable(hit_cnt_r)))
    else $error("tracking state changed without a frame");

  // Raising motion always restarts the hit counter.
  a_motion_clears_hits: assert property (@(posedge clk) disable iff (!rst_n)
    (upd && motion) |=> (hit_cnt_r == '0))
    else $error("hit counter not restarted after motion");

endmodule

[rtl/pir_frame_motion_detector.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pir_frame_motion_detector
// Checks and evaluates captured PIR sensor frames and flags motion.
// ----------------------------------------------------------------------------
// Each request carries one 19-bit frame and produces exactly one result through two
// register stages: the frame is captured in an input register, decoded
// and evaluated against the tracking state in one pass of compare and count
// logic, and written to the result register. A new frame is taken every cycle
// as long as results are drained; the tracking state is updated as a frame
// moves into the result register, so consecutive frames see each other's
// effect without gaps. Configuration writes are applied on the cycle after
// cfg_we and should only be issued while no frame is in flight.
module pir_frame_motion_detector (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic [pfmd_pkg::FRAME_W-1:0]      in_raw_frame,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [pfmd_pkg::SAMPLE_W-1:0]     out_sample_value,
  output logic                              out_frame_valid,
  output logic                              out_motion,
  input  logic                              cfg_we,
  input  logic [pfmd_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [pfmd_pkg::CFG_DAT_W-1:0]    cfg_wdata
);
  import pfmd_pkg::*;

  cfg_t    cfg;
  result_t result;

  logic               s1_valid_r, s1_valid_nxt;
  logic [FRAME_W-1:0] s1_frame_r;
  logic               out_valid_r, out_valid_nxt;
  result_t            out_res_r;
  logic               out_en;
  logic               upd;

  assign out_en   = !out_valid_r || out_ready;
  assign upd      = s1_valid_r && out_en;
  assign in_ready = !s1_valid_r || out_en;

  always_comb begin
    s1_valid_nxt  = s1_valid_r;
    out_valid_nxt = out_valid_r;
    if (in_ready) begin
      s1_valid_nxt = in_valid;
    end
    if (out_en) begin
      out_valid_nxt = s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      s1_frame_r <= in_raw_frame;
    end
    if (upd) begin
      out_res_r <= result;
    end
  end

  pfmd_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  pfmd_core u_core (
    .clk    (clk),
    .rst_n  (rst_n),
    .cfg    (cfg),
    .upd    (upd),
    .frame  (s1_frame_r),
    .result (result)
  );

  assign out_valid        = out_valid_r;
  assign out_sample_value = out_res_r.sample_value;
  assign out_frame_valid  = out_res_r.frame_valid;
  assign out_motion       = out_res_r.motion;

  // A staged frame is never dropped: it stays until it moves on.
  a_stage_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && !out_en) |=> (s1_valid_r && $stable(s1_frame_r)))
    else $error("staged frame lost while the result register was stalled");

  // A waiting result is not overwritten.
  a_result_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_ready) |=> (out_valid_r && $stable(out_res_r)))
    else $error("pending result changed before it was taken");

  // A stalled output never blocks input while the staging register is empty.
  a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !s1_valid_r |-> in_ready)
    else $error("input stalled with an empty staging register");

endmodule

[test/tb_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the PIR frame motion detector. Frames are built
// from a check code and a sample, mostly as slowly drifting valid sample
// streams with noise mixed in. The bench runs a directed part first and then
// random phases under several register settings, the extremes among them.
// A scoreboard class tracks the detector state, predicts each result and
// compares the results in order. Both handshakes idle and stall at random.
// ----------------------------------------------------------------------------
module tb_top;
  import pfmd_pkg::*;

  localparam int CLK_PERIOD     = 12;
  localparam int RESET_CYCLES   = 10;
  localparam int SETTLE_CYCLES  = 4;
  localparam int DRAIN_CYCLES   = 8;
  localparam int LONG_HOLD      = 400;
  localparam int TIMEOUT_CYCLES = 400000;
  localparam int WALK_STEP      = 120;
  localparam int MAX_MAGNITUDE  = 32768;
  localparam int REPORT_LIMIT   = 10;
  localparam int PHASE_COUNT    = 7;

  localparam logic [CFG_IDX_W-1:0] REG_UNUSED_FIRST = REG_HITS_NEEDED + 1'b1;
  localparam logic [CFG_IDX_W-1:0] REG_INDEX_LAST   = '1;

  // Tracks the detector state and holds the results it should produce.
  class motion_scoreboard;
    cfg_t                settings;
    logic [SAMPLE_W-1:0] last_sample;
    logic [SAMPLE_W-1:0] last_step;
    logic [STABLE_W-1:0] stable_run;
    logic [HITS_W-1:0]   hit_run;
    result_t             predicted[$];
    int unsigned         mismatches;

    function new();
      settings.motion_threshold = RST_MOTION_THRESHOLD;
      settings.magnitude_limit  = RST_MAGNITUDE_LIMIT;
      settings.step_limit       = RST_STEP_LIMIT;
      settings.stable_needed    = RST_STABLE_NEEDED;
      settings.hits_needed      = RST_HITS_NEEDED;
      last_sample = '0;
      last_step   = '0;
      stable_run  = '0;
      hit_run     = '0;
      mismatches  = 0;
    endfunction

    function void apply_write(logic [CFG_IDX_W-1:0] idx, logic [CFG_DAT_W-1:0] data);
      case (idx)
        REG_MOTION_THRESHOLD: settings.motion_threshold = data[THRESH_W-1:0];
        REG_MAGNITUDE_LIMIT:  settings.magnitude_limit  = data[SAMPLE_W-1:0];
        REG_STEP_LIMIT:       settings.step_limit       = data[SAMPLE_W-1:0];
        REG_STABLE_NEEDED:    settings.stable_needed    = data[STABLE_W-1:0];
        REG_HITS_NEEDED:      settings.hits_needed      = data[HITS_W-1:0];
        default: ;
      endcase
    endfunction

    function void note_frame(logic [FRAME_W-1:0] frame);
      logic [2:0]          code;
      logic [SAMPLE_W-1:0] mag;
      result_t             r;
      code = {frame[FRAME_W-1], frame[FRAME_W-2], frame[0]};
      mag  = frame[SAMPLE_W:1];
      r.frame_valid = (code == CHECK_OK);
      r.motion      = 1'b0;
      if (r.frame_valid) begin
        // The most negative sample wraps back onto itself.
        if (mag[SAMPLE_W-1])
          mag = ~mag + 1'b1;
        if (mag < settings.magnitude_limit) begin
          if (mag > last_sample)
            last_step = mag - last_sample;
          else if (mag < last_sample)
            last_step = last_sample - mag;
          if (last_step < settings.step_limit) begin
            if (stable_run != STABLE_MAX)
              stable_run++;
            if (mag > settings.motion_threshold && stable_run > settings.stable_needed) begin
              if (hit_run < settings.hits_needed) begin
                hit_run++;
              end else begin
                hit_run  = '0;
                r.motion = 1'b1;
              end
            end else begin
              hit_run = '0;
            end
          end else begin
            stable_run = '0;
          end
        end
        last_sample = mag;
      end
      r.sample_value = mag;
      predicted.push_back(r);
    endfunction

    function void check_result(result_t got);
      result_t want;
      if (predicted.size() == 0) begin
        mismatches++;
        if (mismatches <= REPORT_LIMIT)
          $display("unexpected result: sample %h valid %b motion %b",
                   got.sample_value, got.frame_valid, got.motion);
      end else begin
        want = predicted.pop_front();
        if (got.sample_value !== want.sample_value || got.frame_valid !== want.frame_valid
            || got.motion !== want.motion) begin
          mismatches++;
          if (mismatches <= REPORT_LIMIT)
            $display({"mismatch: expected sample %h valid %b motion %b, ",
                      "got sample %h valid %b motion %b"},
                     want.sample_value, want.frame_valid, want.motion,
                     got.sample_value, got.frame_valid, got.motion);
        end
      end
    endfunction
  endclass

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 in_valid = 1'b0;
  logic                 in_ready;
  logic [FRAME_W-1:0]   in_raw_frame = '0;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  logic [SAMPLE_W-1:0]  out_sample_value;
  logic                 out_frame_valid;
  logic                 out_motion;
  logic                 cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_DAT_W-1:0] cfg_wdata = '0;

  motion_scoreboard sb;
  cfg_t             active_cfg;
  int               walk_level;
  int               burst_left;
  bit               long_hold_req;

  pir_frame_motion_detector uut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_raw_frame     (in_raw_frame),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_sample_value (out_sample_value),
    .out_frame_valid  (out_frame_valid),
    .out_motion       (out_motion),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_wdata        (cfg_wdata)
  );

  initial begin
    forever #(CLK_PERIOD / 2) clk = ~clk;
  end

  initial begin
    #(TIMEOUT_CYCLES * CLK_PERIOD);
    $display("FAIL");
    $finish;
  end

  function automatic logic [FRAME_W-1:0] frame_of(logic [2:0] code, logic [SAMPLE_W-1:0] s);
    return {code[2], code[1], s, code[0]};
  endfunction

  // Mostly a drifting valid sample stream, so the stability and hit counters
  // get exercised; the rest is broken check codes and random frames.
  function automatic logic [FRAME_W-1:0] next_frame();
    int unsigned         pick;
    int                  lvl;
    logic [2:0]          code;
    logic [SAMPLE_W-1:0] s;
    pick = $urandom_range(0, 99);
    if (pick < 8)
      return FRAME_W'($urandom);
    if (pick < 18) begin
      code = 3'($urandom);
      if (code == CHECK_OK)
        code = code ^ 3'b001;
      return frame_of(code, SAMPLE_W'($urandom));
    end
    if (pick < 24)
      return frame_of(CHECK_OK, SAMPLE_W'($urandom));
    lvl  = walk_level;
    pick = $urandom_range(0, 99);
    if (pick >= 15 && pick < 85) begin
      lvl = walk_level + int'($urandom_range(0, 2 * WALK_STEP)) - WALK_STEP;
    end else if (pick >= 85) begin
      case ($urandom_range(0, 5))
        0: lvl = int'(active_cfg.magnitude_limit) - 1;
        1: lvl = int'(active_cfg.magnitude_limit);
        2: lvl = int'(active_cfg.motion_threshold);
        3: lvl = int'(active_cfg.motion_threshold) + 1;
        4: lvl = walk_level + int'(active_cfg.step_limit);
        default: lvl = int'($urandom_range(0, 8000));
      endcase
    end
    if (lvl < 0)
      lvl = -lvl;
    if (lvl > MAX_MAGNITUDE)
      lvl = MAX_MAGNITUDE;
    walk_level = lvl;
    s = lvl[SAMPLE_W-1:0];
    if ($urandom_range(0, 2) == 0)
      s = ~s + 1'b1;
    return frame_of(CHECK_OK, s);
  endfunction

  task automatic push_frame(input logic [FRAME_W-1:0] frame);
    in_valid     <= 1'b1;
    in_raw_frame <= frame;
    @(posedge clk);
    while (!in_ready)
      @(posedge clk);
    sb.note_frame(frame);
  endtask

  task automatic send_random(input int count);
    int gap;
    for (int i = 0; i < count; i++) begin
      push_frame(next_frame());
      burst_left--;
      if (burst_left <= 0) begin
        burst_left = $urandom_range(1, 24);
        gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
        if (gap > 0) begin
          in_valid <= 1'b0;
          repeat (gap) @(posedge clk);
        end
      end
    end
  endtask

  // Registers may only change once every request has left the block.
  task automatic wait_idle();
    in_valid <= 1'b0;
    while (sb.predicted.size() != 0)
      @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DAT_W-1:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    @(posedge clk);
    sb.apply_write(idx, data);
  endtask

  // Upper data bits beyond each register width carry junk, and the unused
  // indexes get random writes that must have no effect.
  task automatic load_config(input cfg_t c);
    for (logic [CFG_IDX_W:0] idx = {1'b0, REG_UNUSED_FIRST}; idx <= {1'b0, REG_INDEX_LAST};
         idx++)
      write_reg(idx[CFG_IDX_W-1:0], CFG_DAT_W'($urandom));
    write_reg(REG_MOTION_THRESHOLD, {3'($urandom), c.motion_threshold});
    write_reg(REG_MAGNITUDE_LIMIT, c.magnitude_limit);
    write_reg(REG_STEP_LIMIT, c.step_limit);
    write_reg(REG_STABLE_NEEDED, {8'($urandom), c.stable_needed});
    write_reg(REG_HITS_NEEDED, {14'($urandom), c.hits_needed});
    cfg_we <= 1'b0;
    repeat (2) @(posedge clk);
    active_cfg = c;
  endtask

  // Result side: checks every accepted result and stalls on its own pattern.
  initial begin : result_side
    int unsigned cycle_count;
    int unsigned stall_mode;
    int unsigned hold_left;
    cycle_count = 0;
    stall_mode  = 0;
    hold_left   = 0;
    forever begin
      @(posedge clk);
      if (rst_n && out_valid && out_ready)
        sb.check_result('{sample_value: out_sample_value, frame_valid: out_frame_valid,
                          motion: out_motion});
      cycle_count++;
      if (cycle_count % 100 == 0)
        stall_mode = $urandom_range(0, 3);
      if (hold_left != 0) begin
        out_ready <= 1'b0;
        hold_left--;
      end else if (long_hold_req) begin
        long_hold_req = 1'b0;
        hold_left     = LONG_HOLD;
        out_ready <= 1'b0;
      end else begin
        case (stall_mode)
          0: out_ready <= 1'b1;
          1: out_ready <= ($urandom_range(0, 1) == 0);
          2: out_ready <= (cycle_count % 4 == 0);
          default: out_ready <= ($urandom_range(0, 99) < 85);
        endcase
      end
    end
  end

  initial begin : stimulus
    cfg_t c;
    sb = new();
    active_cfg    = sb.settings;
    walk_level    = 0;
    burst_left    = 1;
    long_hold_req = 1'b0;
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed part under the reset settings.
    push_frame(frame_of(3'b000, '0));
    push_frame('1);
    push_frame(frame_of(CHECK_OK, 16'h8000));
    push_frame(frame_of(CHECK_OK, 16'h7FFF));
    push_frame(frame_of(CHECK_OK, 16'hFFFF));
    push_frame(frame_of(CHECK_OK, 16'd1));
    push_frame(frame_of(CHECK_OK, 16'd100));
    push_frame(frame_of(CHECK_OK, 16'd100));
    for (logic [3:0] code = 4'd0; code < 4'd8; code++)
      if (code[2:0] != CHECK_OK)
        push_frame(frame_of(code[2:0], SAMPLE_W'($urandom)));
    push_frame(frame_of(CHECK_OK, ~16'd4999 + 1'b1));
    push_frame(frame_of(CHECK_OK, 16'd5000));
    wait_idle();

    // Short hit sequences: motion after two hits, then on every hit.
    c = active_cfg;
    c.stable_needed = '0;
    c.hits_needed   = 2'd1;
    load_config(c);
    push_frame(frame_of(CHECK_OK, 16'd50));
    push_frame(frame_of(CHECK_OK, 16'd60));
    push_frame(frame_of(CHECK_OK, 16'd70));
    push_frame(frame_of(CHECK_OK, 16'd80));
    push_frame(frame_of(CHECK_OK, 16'd30));
    push_frame(frame_of(CHECK_OK, 16'd90));
    push_frame(frame_of(CHECK_OK, 16'd95));
    wait_idle();
    c.hits_needed = '0;
    load_config(c);
    push_frame(frame_of(CHECK_OK, 16'd100));
    push_frame(frame_of(CHECK_OK, 16'd110));
    wait_idle();

    for (int p = 0; p < PHASE_COUNT; p++) begin
      case (p)
        0: c = '{RST_MOTION_THRESHOLD, RST_MAGNITUDE_LIMIT, RST_STEP_LIMIT,
                 RST_STABLE_NEEDED, RST_HITS_NEEDED};
        1: c = '{13'd0, 16'hFFFF, 16'hFFFF, 8'd0, 2'd0};
        2: c = '{13'h1FFF, 16'd0, 16'd0, 8'hFF, 2'd3};
        // The stability counter must saturate before any hit counts here.
        3: c = '{13'd40, 16'd32768, 16'hFFFF, 8'd254, 2'd2};
        4: c = '{13'd4999, 16'd32768, 16'd1, 8'd254, 2'd3};
        default: c = '{13'($urandom_range(0, 200)), 16'($urandom_range(1000, 32768)),
                       16'($urandom_range(2, 400)), 8'($urandom_range(0, 30)),
                       2'($urandom_range(0, 3))};
      endcase
      load_config(c);
      walk_level = $urandom_range(0, 300);
      if (p == 0 || p == 3)
        long_hold_req = 1'b1;
      case (p)
        2, 4: send_random(150);
        3: send_random(450);
        default: send_random(320);
      endcase
      wait_idle();
    end

    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.mismatches == 0 && sb.predicted.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

[pir_frame_motion_detector.f]
rtl/pfmd_pkg.sv
rtl/pfmd_cfg_regs.sv
rtl/pfmd_core.sv
rtl/pir_frame_motion_detector.sv
test/tb_top.sv
